// ===== rtl/core/quoted_field_splitter_core_assert.svh =====
// Assertion macros for the quoted field splitter checker.
// Each macro expects signals named clock and reset in the enclosing scope.
`ifndef QUOTED_FIELD_SPLITTER_CORE_ASSERT_SVH
`define QUOTED_FIELD_SPLITTER_CORE_ASSERT_SVH

// Same-cycle implication, checked at every rising edge outside reset.
`define QFS_ASSERT_NOW(lbl, ante, cons, msg) \
   lbl: assert property (@(posedge clock) disable iff (reset) (ante) |-> (cons)) \
      else $error(msg);

// Next-cycle implication, checked at every rising edge outside reset.
`define QFS_ASSERT_NEXT(lbl, ante, cons, msg) \
   lbl: assert property (@(posedge clock) disable iff (reset) (ante) |=> (cons)) \
      else $error(msg);

`endif

// ===== rtl/core/qfs_pkg.sv =====
// Shared types and constants for the quoted field splitter.
// No dependencies; used by every module of the block.
package qfs_pkg;

   localparam int BYTE_W  = 8;
   localparam int COUNT_W = 32;
   localparam int CSR_IDX_W = 2;

   localparam logic [BYTE_W-1:0] END_OF_STRING = 8'h00;

   localparam logic [BYTE_W-1:0] SEPARATOR_RESET = 8'd44;
   localparam logic [BYTE_W-1:0] QUOTE_RESET     = 8'd34;
   localparam logic [BYTE_W-1:0] ESCAPE_RESET    = 8'd92;

   localparam logic [CSR_IDX_W-1:0] CSR_SEPARATOR = 2'd0;
   localparam logic [CSR_IDX_W-1:0] CSR_QUOTE     = 2'd1;
   localparam logic [CSR_IDX_W-1:0] CSR_ESCAPE    = 2'd2;

   typedef enum logic [4:0] {
      MODE_OUT     = 5'b00001,
      MODE_OUT_ESC = 5'b00010,
      MODE_QUOTED  = 5'b00100,
      MODE_Q_ESC   = 5'b01000,
      MODE_Q_DELIM = 5'b10000
   } mode_type;

   typedef struct packed {
      logic [BYTE_W-1:0]  out_byte;
      logic               has_byte;
      logic               field_end;
      logic               string_end;
      logic               stray_quote_warn;
      logic [COUNT_W-1:0] warn_position;
      logic               config_error;
   } result_type;

endpackage

// ===== rtl/core/qfs_parse.sv =====
// Parser state and per-byte decode of the quoted field splitter.
// Depends on qfs_pkg; holds the configuration registers, mode and byte count.
module qfs_parse
   import qfs_pkg::*;
(
   input  logic                 clock,
   input  logic                 reset,
   input  logic                 csr_write_en,
   input  logic [CSR_IDX_W-1:0] csr_index,
   input  logic [BYTE_W-1:0]    csr_wdata,
   input  logic                 accept,
   input  logic [BYTE_W-1:0]    in_byte,
   output logic                 res_present,
   output result_type           res
);

   logic [BYTE_W-1:0]  separator_ff;
   logic [BYTE_W-1:0]  quote_ff;
   logic [BYTE_W-1:0]  escape_ff;
   mode_type           mode_ff;
   mode_type           mode_in;
   logic [COUNT_W-1:0] count_ff;
   logic [COUNT_W-1:0] count_in;
   logic               quote_zero;
   logic               escape_zero;

   always_ff @(posedge clock) begin
      if (reset) begin
         separator_ff <= SEPARATOR_RESET;
         quote_ff     <= QUOTE_RESET;
         escape_ff    <= ESCAPE_RESET;
      end else if (csr_write_en) begin
         unique case (csr_index)
            CSR_SEPARATOR: separator_ff <= csr_wdata;
            CSR_QUOTE:     quote_ff     <= csr_wdata;
            CSR_ESCAPE:    escape_ff    <= csr_wdata;
            default: ;
         endcase
      end
   end

   always_ff @(posedge clock) begin
      if (reset) begin
         mode_ff  <= MODE_OUT;
         count_ff <= '0;
      end else if (accept) begin
         mode_ff  <= mode_in;
         count_ff <= count_in;
      end
   end

   assign quote_zero  = (quote_ff == END_OF_STRING);
   assign escape_zero = (escape_ff == END_OF_STRING);

   always_comb begin
      mode_in     = mode_ff;
      count_in    = count_ff;
      res_present = 1'b0;
      res         = '0;
      if (quote_zero != escape_zero) begin
         // Half-configured quoting: report and leave the state alone.
         res_present      = 1'b1;
         res.config_error = 1'b1;
      end else if (quote_zero || in_byte == END_OF_STRING) begin
         if (quote_zero) begin
            mode_in = MODE_OUT;
         end
         res_present = 1'b1;
         if (in_byte == END_OF_STRING) begin
            mode_in        = MODE_OUT;
            count_in       = '0;
            res.field_end  = 1'b1;
            res.string_end = 1'b1;
         end else if (in_byte == separator_ff) begin
            res.field_end = 1'b1;
         end else begin
            res.has_byte = 1'b1;
            res.out_byte = in_byte;
         end
      end else begin
         count_in = count_ff + COUNT_W'(1);
         unique case (mode_ff)
            MODE_OUT_ESC: begin
               mode_in      = MODE_OUT;
               res_present  = 1'b1;
               res.has_byte = 1'b1;
               res.out_byte = in_byte;
            end
            MODE_QUOTED: begin
               if (in_byte == quote_ff) begin
                  mode_in = MODE_Q_DELIM;
               end else if (in_byte == escape_ff) begin
                  mode_in = MODE_Q_ESC;
               end else begin
                  res_present  = 1'b1;
                  res.has_byte = 1'b1;
                  res.out_byte = in_byte;
               end
            end
            MODE_Q_ESC: begin
               mode_in      = MODE_QUOTED;
               res_present  = 1'b1;
               res.has_byte = 1'b1;
               res.out_byte = in_byte;
            end
            MODE_Q_DELIM: begin
               res_present = 1'b1;
               if (in_byte == quote_ff) begin
                  mode_in      = MODE_QUOTED;
                  res.has_byte = 1'b1;
                  res.out_byte = in_byte;
               end else if (in_byte == separator_ff) begin
                  mode_in       = MODE_OUT;
                  res.field_end = 1'b1;
               end else begin
                  // The position is the count before this byte was consumed.
                  mode_in              = MODE_QUOTED;
                  res.has_byte         = 1'b1;
                  res.out_byte         = in_byte;
                  res.stray_quote_warn = 1'b1;
                  res.warn_position    = count_ff;
               end
            end
            default: begin
               mode_in = MODE_OUT;
               if (in_byte == separator_ff) begin
                  res_present   = 1'b1;
                  res.field_end = 1'b1;
               end else if (in_byte == quote_ff) begin
                  mode_in = MODE_QUOTED;
               end else if (in_byte == escape_ff) begin
                  mode_in = MODE_OUT_ESC;
               end else begin
                  res_present  = 1'b1;
                  res.has_byte = 1'b1;
                  res.out_byte = in_byte;
               end
            end
         endcase
      end
   end

endmodule

// ===== rtl/core/qfs_out_reg.sv =====
// Result register of the quoted field splitter with valid/ready handshake.
// Depends on qfs_pkg for the result type.
module qfs_out_reg
   import qfs_pkg::*;
(
   input  logic       clock,
   input  logic       reset,
   input  logic       load,
   input  result_type load_data,
   output logic       can_load,
   output logic       out_valid,
   input  logic       out_ready,
   output result_type out_data
);

   logic       valid_ff;
   logic       valid_in;
   result_type data_ff;

   // The register frees up in the same cycle its transfer completes.
   assign can_load = !valid_ff || out_ready;
   assign valid_in = load || (valid_ff && !out_ready);

   always_ff @(posedge clock) begin
      if (reset) begin
         valid_ff <= 1'b0;
      end else begin
         valid_ff <= valid_in;
      end
   end

   always_ff @(posedge clock) begin
      if (load) begin
         data_ff <= load_data;
      end
   end

   assign out_valid = valid_ff;
   assign out_data  = data_ff;

endmodule

// ===== rtl/core/quoted_field_splitter_core.sv =====
// Top level of the quoted field splitter: parser plus result register.
// Depends on qfs_pkg, qfs_parse and qfs_out_reg.
//
//   channel  | handshake            | payload
//   req      | req_valid/req_ready  | req_in_byte
//   rsp      | rsp_valid/rsp_ready  | rsp_out_byte .. rsp_config_error
//   csr      | csr_write_en         | csr_index, csr_wdata
//
// One byte is accepted per cycle while req_ready is high; its result, if any,
// appears on rsp in the cycle after the transfer. The parser decodes the byte
// against the current mode combinationally, loading the single result register.
// A stalled rsp blocks req only while the result register is full and unread.
// Synchronous reset restores the register defaults, outside mode, count zero.
module quoted_field_splitter_core
   import qfs_pkg::*;
(
   input  logic                 clock,
   input  logic                 reset,
   input  logic                 csr_write_en,
   input  logic [CSR_IDX_W-1:0] csr_index,
   input  logic [BYTE_W-1:0]    csr_wdata,
   input  logic                 req_valid,
   output logic                 req_ready,
   input  logic [BYTE_W-1:0]    req_in_byte,
   output logic                 rsp_valid,
   input  logic                 rsp_ready,
   output logic [BYTE_W-1:0]    rsp_out_byte,
   output logic                 rsp_has_byte,
   output logic                 rsp_field_end,
   output logic                 rsp_string_end,
   output logic                 rsp_stray_quote_warn,
   output logic [COUNT_W-1:0]   rsp_warn_position,
   output logic                 rsp_config_error
);

   logic       accept;
   logic       res_present;
   result_type res;
   result_type rsp_data;

   assign accept = req_valid && req_ready;

   qfs_parse u_parse (
      .clock        (clock),
      .reset        (reset),
      .csr_write_en (csr_write_en),
      .csr_index    (csr_index),
      .csr_wdata    (csr_wdata),
      .accept       (accept),
      .in_byte      (req_in_byte),
      .res_present  (res_present),
      .res          (res)
   );

   qfs_out_reg u_out (
      .clock     (clock),
      .reset     (reset),
      .load      (accept && res_present),
      .load_data (res),
      .can_load  (req_ready),
      .out_valid (rsp_valid),
      .out_ready (rsp_ready),
      .out_data  (rsp_data)
   );

   assign rsp_out_byte         = rsp_data.out_byte;
   assign rsp_has_byte         = rsp_data.has_byte;
   assign rsp_field_end        = rsp_data.field_end;
   assign rsp_string_end       = rsp_data.string_end;
   assign rsp_stray_quote_warn = rsp_data.stray_quote_warn;
   assign rsp_warn_position    = rsp_data.warn_position;
   assign rsp_config_error     = rsp_data.config_error;

endmodule

// ===== rtl/core/qfs_checker.sv =====
// Port-level checker for quoted_field_splitter_core and its bind.
// Depends on qfs_pkg and quoted_field_splitter_core_assert.svh.
`include "quoted_field_splitter_core_assert.svh"

module qfs_checker
   import qfs_pkg::*;
(
   input logic               clock,
   input logic               reset,
   input logic               req_ready,
   input logic               rsp_valid,
   input logic               rsp_ready,
   input logic [BYTE_W-1:0]  rsp_out_byte,
   input logic               rsp_has_byte,
   input logic               rsp_field_end,
   input logic               rsp_string_end,
   input logic               rsp_stray_quote_warn,
   input logic               rsp_config_error
);

   `QFS_ASSERT_NOW(a_ready_when_empty, !rsp_valid, req_ready, "req_ready low with empty result register")
   `QFS_ASSERT_NOW(a_error_alone, rsp_valid && rsp_config_error, !rsp_has_byte && !rsp_field_end && !rsp_stray_quote_warn, "config error combined with other flags")
   `QFS_ASSERT_NOW(a_kinds_exclusive, rsp_valid && (rsp_string_end || rsp_stray_quote_warn), (rsp_string_end ? (rsp_field_end && !rsp_has_byte) : (rsp_has_byte && !rsp_field_end)), "inconsistent end or warning flags")
   `QFS_ASSERT_NEXT(a_rsp_hold, rsp_valid && !rsp_ready, rsp_valid && $stable(rsp_out_byte) && $stable(rsp_field_end), "stalled result transfer changed")

endmodule

bind quoted_field_splitter_core qfs_checker u_qfs_checker (
   .clock                (clock),
   .reset                (reset),
   .req_ready            (req_ready),
   .rsp_valid            (rsp_valid),
   .rsp_ready            (rsp_ready),
   .rsp_out_byte         (rsp_out_byte),
   .rsp_has_byte         (rsp_has_byte),
   .rsp_field_end        (rsp_field_end),
   .rsp_string_end       (rsp_string_end),
   .rsp_stray_quote_warn (rsp_stray_quote_warn),
   .rsp_config_error     (rsp_config_error)
);
